// File: design/k_way_sorted_merge_defines.svh
// Assertion macros used by the checker of the k-way merge block.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwm assertion failed");

`endif

// File: design/kwm_pkg.sv
// Package with the shared constants and types of the k-way merge block.
package kwm_pkg;

  localparam int KWM_NUM_LISTS  = 8;
  localparam int KWM_LIST_DEPTH = 8;
  localparam int LIST_IDX_W     = 3;
  localparam int VALUE_W        = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PICK,
    ST_FETCH
  } kwm_state_t;

endpackage

// File: design/kwm_in_if.sv
// Input channel interface: one tagged element per request.
interface kwm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [kwm_pkg::LIST_IDX_W-1:0] list_index;
  logic signed [kwm_pkg::VALUE_W-1:0]    elem_value;
  logic                                  batch_end;

  modport source (output valid, list_index, elem_value, batch_end, input ready);
  modport sink (input valid, list_index, elem_value, batch_end, output ready);
endinterface

// File: design/kwm_out_if.sv
// Result channel interface: one merged element per request.
interface kwm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kwm_pkg::VALUE_W-1:0]    merged_value;
  logic        [kwm_pkg::LIST_IDX_W-1:0] source_list;
  logic                                  run_last;
  logic                                  overflow_seen;

  modport source (output valid, merged_value, source_list, run_last, overflow_seen,
                  input ready);
  modport sink (input valid, merged_value, source_list, run_last, overflow_seen,
                output ready);
endinterface

// File: design/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: design/k_way_sorted_merge.sv
// Top level of the k-way merge block: per-list element stores and merged emission.
//
// Requests arrive on in_ch, each carrying an element and the list it belongs to.
// Elements are appended to their list's store, one request per cycle while
// loading. An element for a full list or for a list index of NUM_LISTS or more is
// dropped, and every result of that batch then shows overflow_seen.
// A request with batch_end set is stored like any other and then starts the
// emission: in_ch stays not ready until the last result has been selected.
// Each result is the smallest head over all lists, the lower list index winning
// ties; ST_PICK selects it from the head registers, waiting while out_ch holds
// a result, and ST_FETCH then refills the head of that list from the element
// RAM. run_last marks the last result. A batch with no stored element gives no
// result; ST_PICK then finds nothing left and frees the input by returning to
// ST_LOAD.
// Results sit in an output register, so a stall on out_ch only holds the
// selection until the register is taken; nothing is lost or repeated.
// Reset empties all lists and clears the drop flag; the RAM needs no clearing.
module k_way_sorted_merge #(
  parameter int NUM_LISTS  = kwm_pkg::KWM_NUM_LISTS,
  parameter int LIST_DEPTH = kwm_pkg::KWM_LIST_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  kwm_in_if.sink   in_ch,
  kwm_out_if.source out_ch
);
  import kwm_pkg::*;

  localparam int LW  = $clog2(NUM_LISTS);
  localparam int SW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int RW  = $clog2(NUM_LISTS * LIST_DEPTH + 1);
  localparam int NP  = 1 << LW;
  localparam int IXW = ((LW > LIST_IDX_W) ? LW : LIST_IDX_W) + 1;
  localparam int AW  = LW + SW;

  kwm_state_t state_r, state_nxt;

  logic        [CW-1:0]      fc_r [NUM_LISTS];
  logic        [CW-1:0]      hd_r [NUM_LISTS];
  logic signed [VALUE_W-1:0] head_val_r [NUM_LISTS];
  logic                      drop_r;
  logic        [RW-1:0]      rem_r;
  logic        [LW-1:0]      best_r;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [LIST_IDX_W-1:0]     out_src_r;
  logic                      out_last_r;
  logic                      out_ovf_r;

  logic                      in_fire;
  logic                      in_ready;
  logic                      pick_go;
  logic                      clear_go;
  logic [IXW-1:0]            in_idx_w;
  logic                      in_range;
  logic [LW-1:0]             lidx;
  logic                      store_go;
  logic [CW-1:0]             hd_inc;

  logic signed [VALUE_W-1:0] tv  [2*NP];
  logic                      tok [2*NP];
  logic [LW-1:0]             tid [2*NP];

  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  assign in_idx_w = IXW'(in_ch.list_index);
  assign in_range = in_idx_w < IXW'(NUM_LISTS);
  assign lidx     = in_idx_w[LW-1:0];
  assign in_fire  = in_ch.valid && in_ready;
  assign store_go = in_fire && in_range && (fc_r[lidx] != CW'(LIST_DEPTH));

  // Selection tree over the head registers; the left child wins ties.
  always_comb begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      tv[NP+i]  = head_val_r[i];
      tok[NP+i] = hd_r[i] < fc_r[i];
      tid[NP+i] = LW'(i);
    end
    for (int i = NUM_LISTS; i < NP; i++) begin
      tv[NP+i]  = '0;
      tok[NP+i] = 1'b0;
      tid[NP+i] = LW'(i);
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (tok[2*n+1] && (!tok[2*n] || (tv[2*n+1] < tv[2*n]))) begin
        tv[n]  = tv[2*n+1];
        tok[n] = 1'b1;
        tid[n] = tid[2*n+1];
      end else begin
        tv[n]  = tv[2*n];
        tok[n] = tok[2*n];
        tid[n] = tid[2*n];
      end
    end
    tv[0]  = '0;
    tok[0] = 1'b0;
    tid[0] = '0;
  end

  assign hd_inc    = hd_r[tid[1]] + CW'(1);
  assign ram_waddr = {lidx, fc_r[lidx][SW-1:0]};
  assign ram_raddr = {tid[1], hd_inc[SW-1:0]};

  kwm_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NUM_LISTS << SW)
  ) u_store (
    .clk  (clk),
    .we   (store_go),
    .waddr(ram_waddr),
    .wdata(in_ch.elem_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_ch.batch_end) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (rem_r == '0) begin
          state_nxt = ST_LOAD;
        end else if (pick_go) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PICK;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    pick_go  = 1'b0;
    clear_go = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
      end
      ST_PICK: begin
        clear_go = (rem_r == '0);
        pick_go  = (rem_r != '0) && (!out_valid_r || out_ch.ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      drop_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fc_r[i] <= '0;
        hd_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clear_go) begin
        drop_r <= 1'b0;
        for (int i = 0; i < NUM_LISTS; i++) begin
          fc_r[i] <= '0;
          hd_r[i] <= '0;
        end
      end
      if (store_go) begin
        fc_r[lidx] <= fc_r[lidx] + CW'(1);
        rem_r      <= rem_r + RW'(1);
      end else if (in_fire) begin
        drop_r <= 1'b1;
      end
      if (pick_go) begin
        hd_r[tid[1]] <= hd_inc;
        rem_r        <= rem_r - RW'(1);
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_go && (fc_r[lidx] == '0)) begin
      head_val_r[lidx] <= in_ch.elem_value;
    end
    if (state_r == ST_FETCH) begin
      head_val_r[best_r] <= ram_rdata;
    end
    if (pick_go) begin
      best_r      <= tid[1];
      out_value_r <= tv[1];
      out_src_r   <= LIST_IDX_W'(tid[1]);
      out_last_r  <= (rem_r == RW'(1));
      out_ovf_r   <= drop_r;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.merged_value  = out_value_r;
  assign out_ch.source_list   = out_src_r;
  assign out_ch.run_last      = out_last_r;
  assign out_ch.overflow_seen = out_ovf_r;
endmodule

// File: design/kwm_checker.sv
// Port-level checker for the k-way merge block and its bind to the top level.
`include "k_way_sorted_merge_defines.svh"

module kwm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_batch_end,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [kwm_pkg::VALUE_W-1:0]    out_merged_value,
  input logic        [kwm_pkg::LIST_IDX_W-1:0] out_source_list,
  input logic                                  out_run_last,
  input logic                                  out_overflow_seen
);
  // A stalled result holds its payload.
  `KWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_merged_value) && $stable(out_source_list) && $stable(out_run_last) && $stable(out_overflow_seen))

  // A closing request blocks the input in the following cycle.
  `KWM_ASSERT_NEXT(a_batch_blocks, clk, rst_n, in_valid && in_ready && in_batch_end, !in_ready)

  // No request is taken while a batch is still being emitted.
  `KWM_ASSERT_SAME(a_emit_blocks, clk, rst_n, out_valid && !out_run_last, !in_ready)

  // No new result appears while the block is still taking requests.
  `KWM_ASSERT_NEXT(a_quiet_while_loading, clk, rst_n, !out_valid && in_ready, !out_valid)
endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_batch_end     (in_ch.batch_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_merged_value (out_ch.merged_value),
  .out_source_list  (out_ch.source_list),
  .out_run_last     (out_ch.run_last),
  .out_overflow_seen(out_ch.overflow_seen)
);
